@@ design/unicycle_odometry_integrator_unit_macros.svh @@
// Assertion helpers shared by the odometry integrator.
// Both sample on clk and are held off while rst_n is low.
`ifndef UNICYCLE_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH
`define UNICYCLE_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UOI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometry integrator check failed");

// Consequent must hold in the cycle after the antecedent.
`define UOI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometry integrator check failed");

`endif

@@ design/uoi_pkg.sv @@
`timescale 1ns / 1ps
package uoi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W   = 5;

  localparam logic signed [31:0] CORDIC_GAIN      = 32'sd652032874;
  localparam logic signed [31:0] TURN_PER_RAD_Q24 = 32'sd2670177;
  localparam logic [15:0]        TICK_PERIOD_RST  = 16'd3277;

  typedef enum logic [3:0] {
    S_IDLE,
    S_VDT,
    S_WDT,
    S_HHI,
    S_HLO,
    S_HSUM,
    S_WAITC,
    S_MX,
    S_MY,
    S_SUMY,
    S_FIN
  } uoi_state_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } uoi_quad_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic signed [31:0] cordic_atan(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] a;
    case (idx)
      5'd0:    a = 32'sh20000000;
      5'd1:    a = 32'sh12E4051E;
      5'd2:    a = 32'sh09FB385B;
      5'd3:    a = 32'sh051111D4;
      5'd4:    a = 32'sh028B0D43;
      5'd5:    a = 32'sh0145D7E1;
      5'd6:    a = 32'sh00A2F61E;
      5'd7:    a = 32'sh00517C55;
      5'd8:    a = 32'sh0028BE53;
      5'd9:    a = 32'sh00145F2F;
      5'd10:   a = 32'sh000A2F98;
      5'd11:   a = 32'sh000517CC;
      5'd12:   a = 32'sh00028BE6;
      5'd13:   a = 32'sh000145F3;
      5'd14:   a = 32'sh0000A2FA;
      5'd15:   a = 32'sh0000517D;
      5'd16:   a = 32'sh000028BE;
      5'd17:   a = 32'sh0000145F;
      5'd18:   a = 32'sh00000A30;
      5'd19:   a = 32'sh00000518;
      5'd20:   a = 32'sh0000028C;
      5'd21:   a = 32'sh00000146;
      5'd22:   a = 32'sh000000A3;
      5'd23:   a = 32'sh00000051;
      default: a = 32'sh00000000;
    endcase
    return a;
  endfunction

endpackage

@@ design/uoi_mul.sv @@
`timescale 1ns / 1ps
module uoi_mul import uoi_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [63:0] prod
);

  logic signed [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

@@ design/uoi_cordic.sv @@
`timescale 1ns / 1ps
module uoi_cordic import uoi_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [31:0] cos_val,
  output logic signed [31:0] sin_val
);

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  logic                     busy_r, busy_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;
  logic signed [31:0]       x_r, x_nxt;
  logic signed [31:0]       y_r, y_nxt;
  logic signed [31:0]       z_r, z_nxt;
  uoi_quad_t                quad_r, quad_nxt;
  logic signed [31:0]       xs, ys, atan_val;

  always_comb begin
    xs       = x_r >>> iter_r;
    ys       = y_r >>> iter_r;
    atan_val = cordic_atan(ATAN_IDX_W'(iter_r));
    busy_nxt = busy_r;
    iter_nxt = iter_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    quad_nxt = quad_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = {2'b00, angle[29:0]};
      quad_nxt = uoi_quad_t'(angle[31:30]);
    end else if (busy_r) begin
      if (!z_r[31]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_val;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_val;
      end
      if (iter_r == ITER_LAST) begin
        busy_nxt = 1'b0;
      end else begin
        iter_nxt = iter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    quad_r <= quad_nxt;
  end

  // fold the first-quadrant result back into the full turn
  always_comb begin
    case (quad_r)
      QUAD_0: begin
        cos_val = x_r;
        sin_val = y_r;
      end
      QUAD_1: begin
        cos_val = -y_r;
        sin_val = x_r;
      end
      QUAD_2: begin
        cos_val = -x_r;
        sin_val = -y_r;
      end
      QUAD_3: begin
        cos_val = y_r;
        sin_val = -x_r;
      end
      default: begin
        cos_val = x_r;
        sin_val = y_r;
      end
    endcase
  end

  assign busy = busy_r;

endmodule

@@ design/unicycle_odometry_integrator_unit.sv @@
// in_tready only when idle: a new tick is not taken until the last one leaves S_FIN.
// The iterative CORDIC runs while the shared 32x32 multiplier works through S_VDT to
// S_HSUM beside it; S_WAITC then holds until the CORDIC is no longer busy.
// Reset (rst_n low, synchronous): pose and heading clear to zero, tick period to 3277,
// no result pending.
`timescale 1ns / 1ps
`include "unicycle_odometry_integrator_unit_macros.svh"
module unicycle_odometry_integrator_unit import uoi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // tick_period
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,      // [23:0] lin_vel, [47:24] ang_vel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata      // [47:0] pos_x_out, [95:48] pos_y_out,
                                      // [127:96] heading_out
);

  localparam logic signed [39:0] STEP_RND = 40'sd128;
  localparam logic signed [63:0] HEAD_RND = 64'sd8388608;
  localparam logic signed [63:0] DISP_RND = 64'sd137438953472;

  uoi_state_t         state_r, state_nxt;
  logic [15:0]        tick_period_r, tick_period_nxt;
  logic signed [23:0] v_r, v_nxt;
  logic signed [23:0] w_r, w_nxt;
  logic signed [31:0] step_r, step_nxt;
  logic [15:0]        wlo_r, wlo_nxt;
  logic signed [47:0] hk_r, hk_nxt;
  logic [31:0]        dh_r, dh_nxt;
  logic signed [25:0] dx_r, dx_nxt;
  logic signed [25:0] dy_r, dy_nxt;
  logic signed [47:0] pos_x_r, pos_x_nxt;
  logic signed [47:0] pos_y_r, pos_y_nxt;
  logic [31:0]        heading_r, heading_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_prod;
  logic               cordic_start, cordic_busy;
  logic signed [31:0] cos_val, sin_val;
  logic signed [39:0] step_sum;
  logic signed [63:0] head_sum;
  logic signed [63:0] disp_sum;

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] pos,
                                                 input logic signed [25:0] d);
    logic signed [48:0] s;
    logic signed [47:0] r;
    s = {pos[47], pos} + 49'(d);
    if (s[48] != s[47]) begin
      r = s[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
    end else begin
      r = s[47:0];
    end
    return r;
  endfunction

  uoi_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_prod)
  );

  uoi_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle   (heading_r),
    .busy    (cordic_busy),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  assign in_tready    = (state_r == S_IDLE);
  assign cordic_start = in_tvalid && in_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {heading_r, pos_y_r, pos_x_r};

  assign step_sum = mul_prod[39:0] + STEP_RND;
  assign head_sum = {hk_r, 16'h0000} + mul_prod + HEAD_RND;
  assign disp_sum = mul_prod + DISP_RND;

  always_comb begin
    state_nxt       = state_r;
    tick_period_nxt = cfg_wr_en ? cfg_wr_data : tick_period_r;
    v_nxt           = v_r;
    w_nxt           = w_r;
    step_nxt        = step_r;
    wlo_nxt         = wlo_r;
    hk_nxt          = hk_r;
    dh_nxt          = dh_r;
    dx_nxt          = dx_r;
    dy_nxt          = dy_r;
    pos_x_nxt       = pos_x_r;
    pos_y_nxt       = pos_y_r;
    heading_nxt     = heading_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    mul_a           = '0;
    mul_b           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          v_nxt     = in_tdata[23:0];
          w_nxt     = in_tdata[47:24];
          state_nxt = S_VDT;
        end
      end
      S_VDT: begin
        mul_a     = 32'(v_r);
        mul_b     = {16'h0000, tick_period_r};
        state_nxt = S_WDT;
      end
      S_WDT: begin
        mul_a     = 32'(w_r);
        mul_b     = {16'h0000, tick_period_r};
        step_nxt  = step_sum[39:8];
        state_nxt = S_HHI;
      end
      S_HHI: begin
        // split w*dt so each partial product fits the 32x32 unit
        mul_a     = 32'(signed'(mul_prod[39:16]));
        mul_b     = TURN_PER_RAD_Q24;
        wlo_nxt   = mul_prod[15:0];
        state_nxt = S_HLO;
      end
      S_HLO: begin
        mul_a     = {16'h0000, wlo_r};
        mul_b     = TURN_PER_RAD_Q24;
        hk_nxt    = mul_prod[47:0];
        state_nxt = S_HSUM;
      end
      S_HSUM: begin
        dh_nxt    = head_sum[55:24];
        state_nxt = S_WAITC;
      end
      S_WAITC: begin
        if (!cordic_busy) begin
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        mul_a     = step_r;
        mul_b     = cos_val;
        state_nxt = S_MY;
      end
      S_MY: begin
        mul_a     = step_r;
        mul_b     = sin_val;
        dx_nxt    = disp_sum[63:38];
        state_nxt = S_SUMY;
      end
      S_SUMY: begin
        dy_nxt    = disp_sum[63:38];
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the pose until the previous result beat is gone
        if (!out_valid_r || out_tready) begin
          pos_x_nxt     = sat_add(pos_x_r, dx_r);
          pos_y_nxt     = sat_add(pos_y_r, dy_r);
          heading_nxt   = heading_r + dh_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      tick_period_r <= TICK_PERIOD_RST;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      heading_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      tick_period_r <= tick_period_nxt;
      pos_x_r       <= pos_x_nxt;
      pos_y_r       <= pos_y_nxt;
      heading_r     <= heading_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    w_r    <= w_nxt;
    step_r <= step_nxt;
    wlo_r  <= wlo_nxt;
    hk_r   <= hk_nxt;
    dh_r   <= dh_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
  end

  `UOI_ASSERT_NEXT(a_cordic_starts, in_tvalid && in_tready, cordic_busy)
  `UOI_ASSERT_SAME(a_no_accept_busy, in_tvalid && in_tready, !cordic_busy)
  `UOI_ASSERT_SAME(a_pose_x_in_fin, pos_x_r != $past(pos_x_r), $past(state_r == S_FIN))
  `UOI_ASSERT_SAME(a_heading_in_fin, heading_r != $past(heading_r), $past(state_r == S_FIN))

endmodule
